[design/blrle_pkg.sv]
// Package for the bitmap line RLE decompressor.
// Holds the controller state type, sizing and decode constants and register addresses; no dependencies.
package blrle_pkg;

   localparam int unsigned MaxLine   = 4096;
   localparam int unsigned AddrW     = $clog2(MaxLine);
   localparam int unsigned CountW    = 25;  // frame byte count, room for run overshoot
   localparam int unsigned TotalW    = 24;
   localparam int unsigned LineW     = 16;
   localparam int unsigned RunSubst  = 22;

   localparam logic [2:0] CSR_TOTAL_ADDR = 3'd0;
   localparam logic [2:0] CSR_LINE_ADDR  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DEC,
      ST_RD,
      ST_WR,
      ST_FLUSH
   } state_type;

endpackage

[design/bitmap_line_rle_decompressor.sv]
// Bitmap line RLE decompressor, top level.
// Depends on blrle_pkg; checker bound from blrle_checker.sv.

// One compressed byte enters per transaction. The start state takes the byte (a pending literal
// is written there), the decode state takes one flag bit per step, and the flush state ends
// the transaction. Each decoded byte copied from the line store is read from the line memory
// and then written to it at the current position; bytes of a previous-byte run after the first
// are written without a further read.
// Results leave up to two decoded bytes per transaction through an output register; the block
// stalls when a byte is due while a full pair waits and the output register is occupied, and
// when held bytes are to be flushed into an occupied output register. The line store needs no
// clearing after reset: only bytes written in the current frame are ever read.
module bitmap_line_rle_decompressor
   import blrle_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte_a, [15:8] out_byte_b, [17:16] pair_count
   output logic        rsp_tlast,   // end_of_run
   output logic [1:0]  rsp_tuser,   // [0] frame_done, [1] ref_error
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0] line_mem [MaxLine];
   logic [7:0] mem_q_ff;

   state_type state_ff, state_in;
   logic [TotalW-1:0] total_ff, total_in;
   logic [LineW-1:0]  line_ff, line_in;
   logic [15:0] flag_ff, flag_in;
   logic [4:0]  left_ff, left_in;
   logic        half_ff, half_in;
   logic [5:0]  pcode_ff, pcode_in;
   logic [2:0]  plen_ff, plen_in;
   logic        await_ff, await_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [7:0]  byte_ff, byte_in;
   logic [TotalW-1:0] dist_ff, dist_in;
   logic [4:0]  run_ff, run_in;
   logic        fixed_ff, fixed_in;
   logic        have_ff, have_in;
   logic [7:0]  fixv_ff, fixv_in;
   logic        err_ff, err_in;
   logic        ended_ff, ended_in;
   logic [1:0]  hcnt_ff, hcnt_in;
   logic [7:0]  ha_ff, ha_in, hb_ff, hb_in;
   logic        herr_ff, herr_in;
   logic        ov_ff, ov_in;
   logic [23:0] od_ff, od_in;
   logic        olast_ff, olast_in;
   logic [1:0]  ouser_ff, ouser_in;

   logic              out_free, can_emit, emit_go, emit_err, mem_we;
   logic [7:0]        emit_val;
   logic [AddrW-1:0]  rd_addr;
   logic [TotalW-1:0] eff_w;
   logic [5:0]        code;
   logic [2:0]        clen, nfield;
   logic              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = csr_paddr[2] ? {16'd0, line_ff} : {8'd0, total_ff};

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = ouser_ff;

   assign out_free = !ov_ff || rsp_tready;
   assign can_emit = (hcnt_ff != 2'd2) || out_free;
   assign eff_w = ((TotalW'(line_ff) > total_ff) || (line_ff <= 16'd1)) ?
                  total_ff : TotalW'(line_ff);
   assign rd_addr = count_ff[AddrW-1:0] - dist_ff[AddrW-1:0];
   assign mem_we  = emit_go;

   assign code   = pcode_ff | (6'(flag_ff[0]) << plen_ff);
   assign clen   = plen_ff + 3'd1;
   assign nfield = code[5:3];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[count_ff[AddrW-1:0]] <= emit_val;
      end
      mem_q_ff <= line_mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      total_in = total_ff;
      line_in  = line_ff;
      flag_in  = flag_ff;
      left_in  = left_ff;
      half_in  = half_ff;
      pcode_in = pcode_ff;
      plen_in  = plen_ff;
      await_in = await_ff;
      count_in = count_ff;
      byte_in  = byte_ff;
      dist_in  = dist_ff;
      run_in   = run_ff;
      fixed_in = fixed_ff;
      have_in  = have_ff;
      fixv_in  = fixv_ff;
      err_in   = err_ff;
      ended_in = ended_ff;
      hcnt_in  = hcnt_ff;
      ha_in    = ha_ff;
      hb_in    = hb_ff;
      herr_in  = herr_ff;
      ov_in    = ov_ff && !rsp_tready;
      od_in    = od_ff;
      olast_in = olast_ff;
      ouser_in = ouser_ff;
      emit_go  = 1'b0;
      emit_val = byte_ff;
      emit_err = 1'b0;

      if (csr_wr) begin
         if (csr_paddr[2]) begin
            line_in = csr_pwdata[LineW-1:0];
         end else begin
            total_in = csr_pwdata[TotalW-1:0];
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               byte_in  = req_tdata;
               ended_in = 1'b0;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (await_ff) begin
               if (can_emit) begin
                  emit_go  = 1'b1;
                  emit_val = byte_ff;
                  await_in = 1'b0;
                  count_in = count_ff + 1'b1;
                  if (count_in >= CountW'(total_ff)) begin
                     ended_in = 1'b1;
                     flag_in = '0; left_in = '0; half_in = 1'b0;
                     pcode_in = '0; plen_in = '0; count_in = '0;
                     state_in = ST_FLUSH;
                  end else begin
                     state_in = ST_DEC;
                  end
               end
            end else begin
               if (!half_ff) begin
                  flag_in = {8'd0, byte_ff};
                  half_in = 1'b1;
               end else begin
                  flag_in = {byte_ff, flag_ff[7:0]};
                  half_in = 1'b0;
                  left_in = 5'd16;
               end
               state_in = ST_DEC;
            end
         end
         ST_DEC: begin
            if (left_ff == 5'd0) begin
               state_in = ST_FLUSH;
            end else begin
               flag_in  = {1'b0, flag_ff[15:1]};
               left_in  = left_ff - 5'd1;
               pcode_in = code;
               plen_in  = clen;
               have_in  = 1'b0;
               fixed_in = 1'b0;
               run_in   = 5'd1;
               if (clen == 3'd1 && !code[0]) begin
                  await_in = 1'b1;
                  pcode_in = '0;
                  plen_in  = '0;
                  state_in = ST_FLUSH;
               end else if (clen == 3'd3 && !code[2]) begin
                  dist_in  = code[1] ? eff_w : TotalW'(1);
                  pcode_in = '0;
                  plen_in  = '0;
                  state_in = ST_RD;
               end else if (clen == 3'd6) begin
                  pcode_in = '0;
                  plen_in  = '0;
                  state_in = ST_RD;
                  if (nfield == 3'd1) begin
                     dist_in = code[1] ? ((eff_w == '0) ? '0 : eff_w - 1'b1) : TotalW'(2);
                  end else begin
                     run_in   = (nfield == 3'd0) ? 5'(RunSubst) : 5'(nfield);
                     dist_in  = code[1] ? eff_w : TotalW'(1);
                     fixed_in = !code[1];
                  end
               end
            end
         end
         ST_RD: begin
            err_in   = (dist_ff == '0) || (CountW'(dist_ff) > CountW'(MaxLine)) ||
                       (CountW'(dist_ff) > count_ff);
            state_in = ST_WR;
         end
         ST_WR: begin
            emit_err = err_ff;
            emit_val = have_ff ? fixv_ff : (err_ff ? 8'd0 : mem_q_ff);
            if (can_emit) begin
               emit_go  = 1'b1;
               count_in = count_ff + 1'b1;
               run_in   = run_ff - 5'd1;
               if (fixed_ff) begin
                  have_in = 1'b1;
                  fixv_in = emit_val;
               end
               if (run_ff == 5'd1) begin
                  if (count_in >= CountW'(total_ff)) begin
                     ended_in = 1'b1;
                     flag_in = '0; left_in = '0; half_in = 1'b0;
                     await_in = 1'b0; count_in = '0;
                     state_in = ST_FLUSH;
                  end else begin
                     state_in = ST_DEC;
                  end
               end else if (!fixed_ff) begin
                  state_in = ST_RD;
               end
            end
         end
         ST_FLUSH: begin
            if (hcnt_ff == 2'd0) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               ov_in    = 1'b1;
               od_in    = {6'd0, hcnt_ff, hb_ff, ha_ff};
               olast_in = 1'b1;
               ouser_in = {herr_ff, ended_ff};
               hcnt_in  = 2'd0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // pair assembly; a full pair moves out only once a later byte proves it is not last
      if (emit_go) begin
         case (hcnt_ff)
            2'd2: begin
               ov_in    = 1'b1;
               od_in    = {6'd0, 2'd2, hb_ff, ha_ff};
               olast_in = 1'b0;
               ouser_in = {herr_ff, 1'b0};
               ha_in = emit_val; hb_in = 8'd0; herr_in = emit_err; hcnt_in = 2'd1;
            end
            2'd1: begin
               hb_in = emit_val; herr_in = herr_ff | emit_err; hcnt_in = 2'd2;
            end
            default: begin
               ha_in = emit_val; hb_in = 8'd0; herr_in = emit_err; hcnt_in = 2'd1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= TotalW'(1);
         line_ff  <= '0;
         flag_ff  <= '0;
         left_ff  <= '0;
         half_ff  <= 1'b0;
         pcode_ff <= '0;
         plen_ff  <= '0;
         await_ff <= 1'b0;
         count_ff <= '0;
         run_ff   <= '0;
         fixed_ff <= 1'b0;
         have_ff  <= 1'b0;
         err_ff   <= 1'b0;
         ended_ff <= 1'b0;
         hcnt_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         line_ff  <= line_in;
         flag_ff  <= flag_in;
         left_ff  <= left_in;
         half_ff  <= half_in;
         pcode_ff <= pcode_in;
         plen_ff  <= plen_in;
         await_ff <= await_in;
         count_ff <= count_in;
         run_ff   <= run_in;
         fixed_ff <= fixed_in;
         have_ff  <= have_in;
         err_ff   <= err_in;
         ended_ff <= ended_in;
         hcnt_ff  <= hcnt_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      dist_ff  <= dist_in;
      fixv_ff  <= fixv_in;
      ha_ff    <= ha_in;
      hb_ff    <= hb_in;
      herr_ff  <= herr_in;
      od_ff    <= od_in;
      olast_ff <= olast_in;
      ouser_ff <= ouser_in;
   end

endmodule

[design/blrle_checker.sv]
// Port-level checker for the bitmap line RLE decompressor.
// Depends on nothing but the top-level ports; bound at the end of this file.
module blrle_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser,
   input logic        csr_pready
);

   // a stalled result transaction stays up
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[17:16] == 2'd1 || rsp_tdata[17:16] == 2'd2))
      else $error("bad pair count");

   // a short pair can only close a run
   a_short: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[17:16] == 2'd1 |-> rsp_tlast && rsp_tdata[15:8] == 8'd0)
      else $error("single byte result not at run end");

   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("frame end not on last result");

   a_ready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port not ready");

endmodule

bind bitmap_line_rle_decompressor blrle_checker u_blrle_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser),
   .csr_pready (csr_pready)
);
